// ===== rtl/core/tse_pkg.sv =====
// Shared types and constants for the TLS server-name extractor.
// Used by tse_parser and by the top level tls_sni_extractor; no dependencies.
package tse_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int OFFSET_W         = 16;
    localparam int REGION_W         = $clog2(MAX_PACKET_BYTES + 1);
    localparam int ACC_W            = 24;
    localparam int NUM_REGIONS      = 5;

    // Region slots, outermost first.
    localparam int REG_RECORD = 0;
    localparam int REG_HS     = 1;
    localparam int REG_EXTS   = 2;
    localparam int REG_SNI    = 3;
    localparam int REG_LIST   = 4;

    localparam logic [7:0]  REC_TYPE_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_TYPE_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_TYPE_SERVER_NAME = 16'h0000;
    localparam logic [15:0] NAME_TYPE_HOST       = 16'h0000;

    localparam logic [OFFSET_W-1:0] REC_OFF_TYPE   = 16'd0;
    localparam logic [OFFSET_W-1:0] REC_OFF_LEN_HI = 16'd3;
    localparam logic [OFFSET_W-1:0] REC_OFF_LEN_LO = 16'd4;
    localparam logic [OFFSET_W-1:0] HS_OFF_TYPE    = 16'd5;
    localparam logic [OFFSET_W-1:0] HS_OFF_LEN_LO  = 16'd8;
    localparam logic [16:0]         REC_HDR_BYTES  = 17'd5;
    localparam logic [24:0]         HS_HDR_END     = 25'd9;

    localparam logic [15:0] RANDOM_SKIP = 16'(2 + 32);
    localparam logic [15:0] SHORT_FIELD = 16'd1;
    localparam logic [15:0] LONG_FIELD  = 16'd2;

    typedef enum logic [2:0] {
        ST_PENDING       = 3'd0,
        ST_FOUND         = 3'd1,
        ST_NOT_HANDSHAKE = 3'd2,
        ST_NOT_HELLO     = 3'd3,
        ST_MALFORMED     = 3'd4,
        ST_NO_NAME       = 3'd5
    } status_t;

    typedef logic [NUM_REGIONS-1:0][REGION_W-1:0] regions_t;

    typedef struct packed {
        logic [7:0] host_byte;
        logic       byte_present;
        status_t    result_status;
        logic       result_last;
    } result_t;

endpackage

// ===== rtl/core/tse_parser.sv =====
// Parse state and combinational next-state logic of the TLS server-name extractor.
// Depends on tse_pkg; instantiated by tls_sni_extractor.
module tse_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        payload_byte,
    input  logic              packet_last,
    output logic              emit,
    output tse_pkg::result_t  result
);

    typedef enum logic [19:0] {
        PH_REC       = 20'h00001,
        PH_HS        = 20'h00002,
        PH_RANDOM    = 20'h00004,
        PH_SID_LEN   = 20'h00008,
        PH_SID       = 20'h00010,
        PH_CS_LEN    = 20'h00020,
        PH_CS        = 20'h00040,
        PH_CM_LEN    = 20'h00080,
        PH_CM        = 20'h00100,
        PH_EXTS_LEN  = 20'h00200,
        PH_EXT_TYPE  = 20'h00400,
        PH_EXT_LEN   = 20'h00800,
        PH_EXT_SKIP  = 20'h01000,
        PH_SNI_LEN   = 20'h02000,
        PH_LIST_LEN  = 20'h04000,
        PH_NAME_TYPE = 20'h08000,
        PH_NAME_LEN  = 20'h10000,
        PH_NAME_SKIP = 20'h20000,
        PH_HOST_LEN  = 20'h40000,
        PH_HOST      = 20'h80000
    } phase_t;

    logic [tse_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    phase_t                       phase_reg, phase_next;
    tse_pkg::regions_t            region_reg, region_next;
    logic [15:0]                  skip_reg, skip_next;
    logic [tse_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic                         done_reg, done_next;

    logic [tse_pkg::OFFSET_W-1:0] off_inc;
    logic [16:0]                  next_off;
    logic [tse_pkg::ACC_W-1:0]    acc_sh;
    logic [15:0]                  skip_dec;
    logic [15:0]                  field_len;
    logic [17:0]                  nested_end;
    logic [16:0]                  rec_end;
    logic [24:0]                  hs_end;
    logic                         has_bound;
    logic [tse_pkg::REGION_W-1:0] bound;
    logic                         out_of_region;

    phase_t                       c_phase;
    logic [15:0]                  c_skip;
    logic [tse_pkg::ACC_W-1:0]    c_acc;
    tse_pkg::regions_t            c_region;
    logic                         c_fin;
    tse_pkg::status_t             c_status;
    logic                         c_present;

    phase_t                       s_phase;
    logic [15:0]                  s_skip;
    logic [tse_pkg::ACC_W-1:0]    s_acc;
    logic                         s_fin;
    tse_pkg::status_t             s_status;

    assign off_inc    = (offset_reg != '1) ? offset_reg + 16'd1 : offset_reg;
    assign next_off   = {1'b0, offset_reg} + 17'd1;
    assign acc_sh     = {acc_reg[15:0], payload_byte};
    assign skip_dec   = (skip_reg != '0) ? skip_reg - 16'd1 : skip_reg;
    assign field_len  = acc_sh[15:0];
    assign nested_end = {1'b0, next_off} + {2'b00, field_len};
    assign rec_end    = tse_pkg::REC_HDR_BYTES + {1'b0, acc_reg[7:0], payload_byte};
    assign hs_end     = tse_pkg::HS_HDR_END + {1'b0, acc_sh};

    // Each phase but PH_REC reads its byte from inside one enclosing region.
    always_comb begin
        has_bound = 1'b1;
        if (phase_reg == PH_REC) begin
            has_bound = 1'b0;
            bound     = '0;
        end else if (phase_reg == PH_HS) begin
            bound = region_reg[tse_pkg::REG_RECORD];
        end else if (phase_reg inside {PH_RANDOM, PH_SID_LEN, PH_SID, PH_CS_LEN, PH_CS,
                                       PH_CM_LEN, PH_CM, PH_EXTS_LEN}) begin
            bound = region_reg[tse_pkg::REG_HS];
        end else if (phase_reg inside {PH_EXT_TYPE, PH_EXT_LEN, PH_EXT_SKIP,
                                       PH_SNI_LEN}) begin
            bound = region_reg[tse_pkg::REG_EXTS];
        end else if (phase_reg == PH_LIST_LEN) begin
            bound = region_reg[tse_pkg::REG_SNI];
        end else begin
            bound = region_reg[tse_pkg::REG_LIST];
        end
    end

    assign out_of_region = has_bound && (offset_reg >= tse_pkg::OFFSET_W'(bound));

    // Consume the current byte.
    always_comb begin
        c_phase   = phase_reg;
        c_skip    = skip_reg;
        c_acc     = acc_reg;
        c_region  = region_reg;
        c_fin     = 1'b0;
        c_status  = tse_pkg::ST_PENDING;
        c_present = 1'b0;
        if (out_of_region) begin
            c_fin    = 1'b1;
            c_status = tse_pkg::ST_MALFORMED;
        end else begin
            case (phase_reg)
                PH_REC: begin
                    if (offset_reg == tse_pkg::REC_OFF_TYPE &&
                        payload_byte != tse_pkg::REC_TYPE_HANDSHAKE) begin
                        c_fin    = 1'b1;
                        c_status = tse_pkg::ST_NOT_HANDSHAKE;
                    end else if (offset_reg == tse_pkg::REC_OFF_LEN_HI) begin
                        c_acc = tse_pkg::ACC_W'(payload_byte);
                    end else if (offset_reg == tse_pkg::REC_OFF_LEN_LO) begin
                        if (rec_end > 17'(tse_pkg::MAX_PACKET_BYTES)) begin
                            c_fin    = 1'b1;
                            c_status = tse_pkg::ST_MALFORMED;
                        end else begin
                            c_region[tse_pkg::REG_RECORD] = tse_pkg::REGION_W'(rec_end);
                            c_phase = PH_HS;
                        end
                    end
                end
                PH_HS: begin
                    if (offset_reg == tse_pkg::HS_OFF_TYPE) begin
                        if (payload_byte != tse_pkg::HS_TYPE_CLIENT_HELLO) begin
                            c_fin    = 1'b1;
                            c_status = tse_pkg::ST_NOT_HELLO;
                        end
                        c_acc = '0;
                    end else begin
                        c_acc = acc_sh;
                        if (offset_reg >= tse_pkg::HS_OFF_LEN_LO) begin
                            if (hs_end > 25'(region_reg[tse_pkg::REG_RECORD])) begin
                                c_fin    = 1'b1;
                                c_status = tse_pkg::ST_MALFORMED;
                            end else begin
                                c_region[tse_pkg::REG_HS] = tse_pkg::REGION_W'(hs_end);
                                c_phase = PH_RANDOM;
                                c_skip  = tse_pkg::RANDOM_SKIP;
                            end
                        end
                    end
                end
                PH_RANDOM, PH_SID, PH_CS, PH_CM, PH_EXT_SKIP, PH_NAME_SKIP: begin
                    c_skip = skip_dec;
                end
                PH_HOST: begin
                    c_present = 1'b1;
                    c_skip    = skip_dec;
                    if (skip_dec == '0) begin
                        c_fin    = 1'b1;
                        c_status = tse_pkg::ST_FOUND;
                    end
                end
                PH_SID_LEN, PH_CS_LEN, PH_CM_LEN, PH_EXTS_LEN, PH_EXT_TYPE, PH_EXT_LEN,
                PH_SNI_LEN, PH_LIST_LEN, PH_NAME_TYPE, PH_NAME_LEN, PH_HOST_LEN: begin
                    c_acc  = acc_sh;
                    c_skip = skip_dec;
                    if (skip_dec == '0) begin
                        case (phase_reg)
                            PH_SID_LEN: begin
                                c_phase = PH_SID;
                                c_skip  = field_len;
                            end
                            PH_CS_LEN: begin
                                c_phase = PH_CS;
                                c_skip  = field_len;
                            end
                            PH_CM_LEN: begin
                                c_phase = PH_CM;
                                c_skip  = field_len;
                            end
                            PH_EXTS_LEN: begin
                                if (nested_end > 18'(region_reg[tse_pkg::REG_HS])) begin
                                    c_fin    = 1'b1;
                                    c_status = tse_pkg::ST_MALFORMED;
                                end else begin
                                    c_region[tse_pkg::REG_EXTS] =
                                        tse_pkg::REGION_W'(nested_end);
                                    c_phase = PH_EXT_TYPE;
                                    c_skip  = tse_pkg::LONG_FIELD;
                                    c_acc   = '0;
                                end
                            end
                            PH_EXT_TYPE: begin
                                c_phase = (field_len == tse_pkg::EXT_TYPE_SERVER_NAME) ?
                                          PH_SNI_LEN : PH_EXT_LEN;
                                c_skip  = tse_pkg::LONG_FIELD;
                                c_acc   = '0;
                            end
                            PH_EXT_LEN: begin
                                c_phase = PH_EXT_SKIP;
                                c_skip  = field_len;
                            end
                            PH_SNI_LEN: begin
                                if (nested_end > 18'(region_reg[tse_pkg::REG_EXTS])) begin
                                    c_fin    = 1'b1;
                                    c_status = tse_pkg::ST_MALFORMED;
                                end else begin
                                    c_region[tse_pkg::REG_SNI] =
                                        tse_pkg::REGION_W'(nested_end);
                                    c_phase = PH_LIST_LEN;
                                    c_skip  = tse_pkg::LONG_FIELD;
                                    c_acc   = '0;
                                end
                            end
                            PH_LIST_LEN: begin
                                if (nested_end > 18'(region_reg[tse_pkg::REG_SNI])) begin
                                    c_fin    = 1'b1;
                                    c_status = tse_pkg::ST_MALFORMED;
                                end else begin
                                    c_region[tse_pkg::REG_LIST] =
                                        tse_pkg::REGION_W'(nested_end);
                                    c_phase = PH_NAME_TYPE;
                                    c_skip  = tse_pkg::SHORT_FIELD;
                                    c_acc   = '0;
                                end
                            end
                            PH_NAME_TYPE: begin
                                c_phase = (field_len == tse_pkg::NAME_TYPE_HOST) ?
                                          PH_HOST_LEN : PH_NAME_LEN;
                                c_skip  = tse_pkg::LONG_FIELD;
                                c_acc   = '0;
                            end
                            PH_NAME_LEN: begin
                                c_phase = PH_NAME_SKIP;
                                c_skip  = field_len;
                            end
                            PH_HOST_LEN: begin
                                if (nested_end > 18'(region_reg[tse_pkg::REG_LIST])) begin
                                    c_fin    = 1'b1;
                                    c_status = tse_pkg::ST_MALFORMED;
                                end else if (field_len == '0) begin
                                    c_fin    = 1'b1;
                                    c_status = tse_pkg::ST_FOUND;
                                end else begin
                                    c_phase = PH_HOST;
                                    c_skip  = field_len;
                                end
                            end
                            default: begin
                                c_fin    = 1'b1;
                                c_status = tse_pkg::ST_MALFORMED;
                            end
                        endcase
                    end
                end
                default: begin
                    c_fin    = 1'b1;
                    c_status = tse_pkg::ST_MALFORMED;
                end
            endcase
        end
    end

    // Leave a finished skip, then check for a region that ended without a match.
    always_comb begin
        s_phase  = c_phase;
        s_skip   = c_skip;
        s_acc    = c_acc;
        s_fin    = c_fin;
        s_status = c_status;
        if (!c_fin) begin
            if (c_skip == '0 && c_phase inside {PH_RANDOM, PH_SID, PH_CS, PH_CM,
                                                PH_EXT_SKIP, PH_NAME_SKIP}) begin
                s_acc = '0;
                case (c_phase)
                    PH_RANDOM: begin
                        s_phase = PH_SID_LEN;
                        s_skip  = tse_pkg::SHORT_FIELD;
                    end
                    PH_SID: begin
                        s_phase = PH_CS_LEN;
                        s_skip  = tse_pkg::LONG_FIELD;
                    end
                    PH_CS: begin
                        s_phase = PH_CM_LEN;
                        s_skip  = tse_pkg::SHORT_FIELD;
                    end
                    PH_CM: begin
                        s_phase = PH_EXTS_LEN;
                        s_skip  = tse_pkg::LONG_FIELD;
                    end
                    PH_EXT_SKIP: begin
                        s_phase = PH_EXT_TYPE;
                        s_skip  = tse_pkg::LONG_FIELD;
                    end
                    PH_NAME_SKIP: begin
                        s_phase = PH_NAME_TYPE;
                        s_skip  = tse_pkg::SHORT_FIELD;
                    end
                    default: begin
                        s_phase = c_phase;
                    end
                endcase
            end
            if (s_phase == PH_EXTS_LEN && s_skip == tse_pkg::LONG_FIELD &&
                off_inc == tse_pkg::OFFSET_W'(c_region[tse_pkg::REG_HS])) begin
                s_fin    = 1'b1;
                s_status = tse_pkg::ST_NO_NAME;
            end else if (s_phase == PH_EXT_TYPE && s_skip == tse_pkg::LONG_FIELD &&
                         off_inc == tse_pkg::OFFSET_W'(c_region[tse_pkg::REG_EXTS])) begin
                s_fin    = 1'b1;
                s_status = tse_pkg::ST_NO_NAME;
            end else if (s_phase == PH_NAME_TYPE &&
                         off_inc == tse_pkg::OFFSET_W'(c_region[tse_pkg::REG_LIST])) begin
                s_fin    = 1'b1;
                s_status = tse_pkg::ST_NO_NAME;
            end
        end
    end

    assign emit                 = !done_reg && (s_fin || c_present || packet_last);
    assign result.host_byte     = c_present ? payload_byte : 8'h00;
    assign result.byte_present  = c_present;
    assign result.result_status = s_fin ? s_status :
                                  (packet_last ? tse_pkg::ST_MALFORMED : tse_pkg::ST_PENDING);
    assign result.result_last   = s_fin || packet_last;

    always_comb begin
        offset_next = offset_reg;
        phase_next  = phase_reg;
        region_next = region_reg;
        skip_next   = skip_reg;
        acc_next    = acc_reg;
        done_next   = done_reg;
        if (step) begin
            if (packet_last) begin
                offset_next = '0;
                phase_next  = PH_REC;
                region_next = '0;
                skip_next   = '0;
                acc_next    = '0;
                done_next   = 1'b0;
            end else begin
                offset_next = off_inc;
                if (!done_reg) begin
                    phase_next  = s_phase;
                    region_next = c_region;
                    skip_next   = s_skip;
                    acc_next    = s_acc;
                    done_next   = s_fin;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            phase_reg  <= PH_REC;
            region_reg <= '0;
            skip_reg   <= '0;
            acc_reg    <= '0;
            done_reg   <= 1'b0;
        end else begin
            offset_reg <= offset_next;
            phase_reg  <= phase_next;
            region_reg <= region_next;
            skip_reg   <= skip_next;
            acc_reg    <= acc_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ===== rtl/core/tls_sni_extractor.sv =====
// Top level of the TLS server-name extractor: input register, result register, handshakes.
// Depends on tse_pkg and tse_parser.
//
// The block takes one TCP payload byte per item and sustains one item per clock cycle when
// not stalled; an accepted item waits in the input register and reaches the result register
// when it advances, because the whole parse update for a byte is combinational logic between
// the two registers. A result is given only for a host-name byte or for the final status of
// a packet, and a packet gets exactly one final result (result_last high), at the latest on
// its last byte. Bytes after the final result, up to packet_last, are taken and dropped.
// The input side stalls only while both registers are full and m_ready is low.
module tls_sni_extractor (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_payload_byte,
    input  logic       s_packet_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_host_byte,
    output logic       m_byte_present,
    output logic [2:0] m_result_status,
    output logic       m_result_last
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg, in_byte_next;
    logic             in_last_reg, in_last_next;
    logic             out_valid_reg, out_valid_next;
    tse_pkg::result_t out_reg, out_next;

    logic             advance;
    logic             emit;
    tse_pkg::result_t result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tse_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .payload_byte (in_byte_reg),
        .packet_last  (in_last_reg),
        .emit         (emit),
        .result       (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_payload_byte;
            in_last_next  = s_packet_last;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance && emit) begin
            out_valid_next = 1'b1;
            out_next       = result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
        out_reg     <= out_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_host_byte     = out_reg.host_byte;
    assign m_byte_present  = out_reg.byte_present;
    assign m_result_status = out_reg.result_status;
    assign m_result_last   = out_reg.result_last;

    a_last_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_result_status == tse_pkg::ST_PENDING) != m_result_last))
        else $error("Final flag disagrees with the result status.");

    a_pending_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_result_last) |-> m_byte_present)
        else $error("A non-final result carries no name byte.");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_status <= tse_pkg::ST_NO_NAME))
        else $error("Result status code out of range.");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("Input taken while both registers are full and stalled.");

endmodule

// ===== bench/tls_sni_extractor_test.sv =====
// Testbench for tls_sni_extractor: streams ClientHello records, damaged records and noise
// one payload byte per item, and checks every result against a behavioral parser model.
// Depends on tse_pkg and the extractor RTL.
module tls_sni_extractor_test;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 600;

    typedef enum int {
        P_RECORD, P_HS_HEADER, P_RANDOM, P_SID_LEN, P_SID, P_CS_LEN, P_CS, P_CM_LEN, P_CM,
        P_EXTS_LEN, P_EXT_TYPE, P_EXT_LEN, P_EXT_SKIP, P_SNI_LEN, P_LIST_LEN,
        P_NAME_TYPE, P_NAME_LEN, P_NAME_SKIP, P_HOST_LEN, P_HOST
    } parse_step_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_payload_byte = 8'h00;
    logic       s_packet_last  = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_host_byte;
    logic       m_byte_present;
    logic [2:0] m_result_status;
    logic       m_result_last;

    int unsigned      sni_offset;
    parse_step_t      sni_step;
    int unsigned      sni_end [tse_pkg::NUM_REGIONS];
    int unsigned      sni_left;
    int unsigned      sni_acc;
    bit               sni_done;
    tse_pkg::status_t out_status;
    logic [7:0]       out_byte;
    bit               out_has_byte;

    tse_pkg::result_t pending_results[$];
    logic [7:0]       frame[$];
    int pos_rec_len, pos_hs_len, pos_exts_len, pos_sni_len, pos_list_len, pos_name_size;

    int mismatches    = 0;
    int bytes_sent    = 0;
    int quiet_cycles  = 0;
    int hold_off_left = 0;
    bit send_gaps     = 1'b1;
    bit recv_stalls   = 1'b1;

    tls_sni_extractor i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload_byte  (s_payload_byte),
        .s_packet_last   (s_packet_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_host_byte     (m_host_byte),
        .m_byte_present  (m_byte_present),
        .m_result_status (m_result_status),
        .m_result_last   (m_result_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void sni_restart();
        sni_offset = 0;
        sni_step   = P_RECORD;
        foreach (sni_end[i]) sni_end[i] = 0;
        sni_left   = 0;
        sni_acc    = 0;
        sni_done   = 1'b0;
    endfunction

    function automatic void sni_finish(tse_pkg::status_t s);
        sni_done   = 1'b1;
        out_status = s;
    endfunction

    function automatic void sni_field(parse_step_t s, int unsigned n);
        sni_step = s;
        sni_left = n;
        sni_acc  = 0;
    endfunction

    function automatic void sni_skip_to(parse_step_t s, int unsigned n);
        sni_step = s;
        sni_left = n & 32'hFFFF;
    endfunction

    function automatic int region_index(parse_step_t s);
        if (s == P_RECORD) return -1;
        if (s == P_HS_HEADER) return tse_pkg::REG_RECORD;
        if (s <= P_EXTS_LEN) return tse_pkg::REG_HS;
        if (s <= P_SNI_LEN) return tse_pkg::REG_EXTS;
        if (s == P_LIST_LEN) return tse_pkg::REG_SNI;
        return tse_pkg::REG_LIST;
    endfunction

    function automatic bit nest_region(int idx, int unsigned region_end);
        if (region_end > sni_end[idx - 1]) begin
            sni_finish(tse_pkg::ST_MALFORMED);
            return 1'b0;
        end
        sni_end[idx] = region_end;
        return 1'b1;
    endfunction

    function automatic bit is_skip(parse_step_t s);
        return s inside {P_RANDOM, P_SID, P_CS, P_CM, P_EXT_SKIP, P_NAME_SKIP};
    endfunction

    function automatic void field_complete(int unsigned next_off);
        int unsigned v;
        v = sni_acc;
        case (sni_step)
            P_SID_LEN: sni_skip_to(P_SID, v);
            P_CS_LEN:  sni_skip_to(P_CS, v);
            P_CM_LEN:  sni_skip_to(P_CM, v);
            P_EXTS_LEN: begin
                if (nest_region(tse_pkg::REG_EXTS, next_off + v))
                    sni_field(P_EXT_TYPE, tse_pkg::LONG_FIELD);
            end
            P_EXT_TYPE: begin
                if (v == tse_pkg::EXT_TYPE_SERVER_NAME) sni_field(P_SNI_LEN, tse_pkg::LONG_FIELD);
                else sni_field(P_EXT_LEN, tse_pkg::LONG_FIELD);
            end
            P_EXT_LEN: sni_skip_to(P_EXT_SKIP, v);
            P_SNI_LEN: begin
                if (nest_region(tse_pkg::REG_SNI, next_off + v))
                    sni_field(P_LIST_LEN, tse_pkg::LONG_FIELD);
            end
            P_LIST_LEN: begin
                if (nest_region(tse_pkg::REG_LIST, next_off + v))
                    sni_field(P_NAME_TYPE, tse_pkg::SHORT_FIELD);
            end
            P_NAME_TYPE: begin
                if (v == tse_pkg::NAME_TYPE_HOST) sni_field(P_HOST_LEN, tse_pkg::LONG_FIELD);
                else sni_field(P_NAME_LEN, tse_pkg::LONG_FIELD);
            end
            P_NAME_LEN: sni_skip_to(P_NAME_SKIP, v);
            P_HOST_LEN: begin
                if (next_off + v > sni_end[tse_pkg::REG_LIST]) sni_finish(tse_pkg::ST_MALFORMED);
                else if (v == 0) sni_finish(tse_pkg::ST_FOUND);
                else sni_skip_to(P_HOST, v);
            end
            default: sni_finish(tse_pkg::ST_MALFORMED);
        endcase
    endfunction

    function automatic void consume_byte(int unsigned cur, logic [7:0] b);
        int          idx;
        int unsigned rec_end;
        idx = region_index(sni_step);
        if (idx >= 0 && cur >= sni_end[idx]) begin
            sni_finish(tse_pkg::ST_MALFORMED);
            return;
        end
        case (sni_step)
            P_RECORD: begin
                if (cur == tse_pkg::REC_OFF_TYPE && b != tse_pkg::REC_TYPE_HANDSHAKE) begin
                    sni_finish(tse_pkg::ST_NOT_HANDSHAKE);
                end else if (cur == tse_pkg::REC_OFF_LEN_HI) begin
                    sni_acc = b;
                end else if (cur == tse_pkg::REC_OFF_LEN_LO) begin
                    rec_end = tse_pkg::REC_HDR_BYTES + ((sni_acc << 8) | b);
                    if (rec_end > tse_pkg::MAX_PACKET_BYTES) begin
                        sni_finish(tse_pkg::ST_MALFORMED);
                        return;
                    end
                    sni_end[tse_pkg::REG_RECORD] = rec_end;
                    sni_step = P_HS_HEADER;
                end
            end
            P_HS_HEADER: begin
                if (cur == tse_pkg::HS_OFF_TYPE) begin
                    if (b != tse_pkg::HS_TYPE_CLIENT_HELLO) sni_finish(tse_pkg::ST_NOT_HELLO);
                    sni_acc = 0;
                end else begin
                    sni_acc = ((sni_acc << 8) | b) & 32'hFFFFFF;
                    if (cur >= tse_pkg::HS_OFF_LEN_LO) begin
                        if (nest_region(tse_pkg::REG_HS, tse_pkg::HS_HDR_END + sni_acc))
                            sni_skip_to(P_RANDOM, tse_pkg::RANDOM_SKIP);
                    end
                end
            end
            P_RANDOM, P_SID, P_CS, P_CM, P_EXT_SKIP, P_NAME_SKIP: begin
                if (sni_left > 0) sni_left--;
            end
            P_HOST: begin
                out_byte     = b;
                out_has_byte = 1'b1;
                if (sni_left > 0) sni_left--;
                if (sni_left == 0) sni_finish(tse_pkg::ST_FOUND);
            end
            default: begin
                sni_acc = ((sni_acc << 8) | b) & 32'hFFFFFF;
                if (sni_left > 0) sni_left--;
                if (sni_left == 0) field_complete(cur + 1);
            end
        endcase
    endfunction

    function automatic void settle_fields(int unsigned off);
        while (!sni_done) begin
            if (sni_left == 0 && is_skip(sni_step)) begin
                case (sni_step)
                    P_RANDOM:   sni_field(P_SID_LEN, tse_pkg::SHORT_FIELD);
                    P_SID:      sni_field(P_CS_LEN, tse_pkg::LONG_FIELD);
                    P_CS:       sni_field(P_CM_LEN, tse_pkg::SHORT_FIELD);
                    P_CM:       sni_field(P_EXTS_LEN, tse_pkg::LONG_FIELD);
                    P_EXT_SKIP: sni_field(P_EXT_TYPE, tse_pkg::LONG_FIELD);
                    default:    sni_field(P_NAME_TYPE, tse_pkg::SHORT_FIELD);
                endcase
                continue;
            end
            if (sni_step == P_EXTS_LEN && sni_left == tse_pkg::LONG_FIELD
                && off == sni_end[tse_pkg::REG_HS])
                sni_finish(tse_pkg::ST_NO_NAME);
            else if (sni_step == P_EXT_TYPE && sni_left == tse_pkg::LONG_FIELD
                     && off == sni_end[tse_pkg::REG_EXTS])
                sni_finish(tse_pkg::ST_NO_NAME);
            else if (sni_step == P_NAME_TYPE && off == sni_end[tse_pkg::REG_LIST])
                sni_finish(tse_pkg::ST_NO_NAME);
            break;
        end
    endfunction

    function automatic void predict_sni(logic [7:0] b, logic last);
        int unsigned      cur;
        bit               emit;
        bit               closing;
        tse_pkg::result_t r;
        cur     = sni_offset;
        emit    = 1'b0;
        closing = 1'b0;
        if (sni_offset < 32'hFFFF) sni_offset++;
        out_status   = tse_pkg::ST_PENDING;
        out_byte     = 8'h00;
        out_has_byte = 1'b0;
        if (!sni_done) begin
            consume_byte(cur, b);
            if (sni_done) begin
                emit    = 1'b1;
                closing = 1'b1;
            end else begin
                settle_fields(sni_offset);
                if (sni_done) begin
                    emit    = 1'b1;
                    closing = 1'b1;
                end else if (out_has_byte) begin
                    emit = 1'b1;
                end
            end
            if (last && !sni_done) begin
                out_status = tse_pkg::ST_MALFORMED;
                emit       = 1'b1;
                closing    = 1'b1;
            end
        end
        if (emit) begin
            r.host_byte     = out_has_byte ? out_byte : 8'h00;
            r.byte_present  = out_has_byte;
            r.result_status = out_status;
            r.result_last   = closing;
            pending_results.push_back(r);
        end
        if (last) sni_restart();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40) $display("mismatch: %s got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        tse_pkg::result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, status", m_result_status, -1);
            end else begin
                want = pending_results.pop_front();
                if (m_host_byte !== want.host_byte)
                    report_mismatch("host_byte", m_host_byte, want.host_byte);
                if (m_byte_present !== want.byte_present)
                    report_mismatch("byte_present", m_byte_present, want.byte_present);
                if (m_result_status !== want.result_status)
                    report_mismatch("result_status", m_result_status, want.result_status);
                if (m_result_last !== want.result_last)
                    report_mismatch("result_last", m_result_last, want.result_last);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int pick;
        int ready_low_left;
        ready_low_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_ready <= 1'b0;
                hold_off_left--;
            end else if (!recv_stalls) begin
                m_ready <= 1'b1;
            end else if (ready_low_left > 0) begin
                m_ready <= 1'b0;
                ready_low_left--;
            end else begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    ready_low_left = (pick < 95) ? $urandom_range(2) : $urandom_range(40, 10);
                end
            end
        end
    end

    function automatic int pick_gap();
        int p;
        if (!send_gaps) return 0;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_payload_byte <= b;
        s_packet_last  <= last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_sni(b, last);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
    endtask

    function automatic void put8(int v);
        frame.push_back(v[7:0]);
    endfunction

    function automatic void put16(int v);
        put8(v >> 8);
        put8(v);
    endfunction

    function automatic void put_random(int n);
        repeat (n) put8($urandom_range(255));
    endfunction

    function automatic void put_other_exts(int n);
        int k;
        repeat (n) begin
            k = $urandom_range(6);
            put16($urandom_range(65535, 1));
            put16(k);
            put_random(k);
        end
    endfunction

    function automatic void patch16(int pos, int v);
        frame[pos]     = v[15:8];
        frame[pos + 1] = v[7:0];
    endfunction

    function automatic void patch_len16(int pos);
        patch16(pos, frame.size() - pos - 2);
    endfunction

    function automatic void patch24(int pos, int v);
        frame[pos] = v[23:16];
        patch16(pos + 1, v);
    endfunction

    function automatic void bump16(int pos, int delta);
        logic [15:0] v;
        v = {frame[pos], frame[pos + 1]};
        patch16(pos, int'(v) + delta);
    endfunction

    function automatic void truncate_frame(int keep);
        while (frame.size() > keep) void'(frame.pop_back());
    endfunction

    // A name_size below zero leaves the host_name entry out of the name list.
    function automatic void build_hello(int sid_len, int cs_len, int cm_len, int n_pre_ext,
                                        bit with_exts, bit with_sni, int n_pre_names,
                                        int name_size, int n_post_ext, int tail_len);
        int k;
        frame.delete();
        pos_exts_len  = -1;
        pos_sni_len   = -1;
        pos_list_len  = -1;
        pos_name_size = -1;
        put8(tse_pkg::REC_TYPE_HANDSHAKE);
        put16(16'h0301);
        pos_rec_len = frame.size();
        put16(0);
        put8(tse_pkg::HS_TYPE_CLIENT_HELLO);
        pos_hs_len = frame.size();
        put8(0);
        put16(0);
        put16(16'h0303);
        put_random(32);
        put8(sid_len);
        put_random(sid_len);
        put16(cs_len);
        put_random(cs_len);
        put8(cm_len);
        put_random(cm_len);
        if (with_exts) begin
            pos_exts_len = frame.size();
            put16(0);
            put_other_exts(n_pre_ext);
            if (with_sni) begin
                put16(tse_pkg::EXT_TYPE_SERVER_NAME);
                pos_sni_len = frame.size();
                put16(0);
                pos_list_len = frame.size();
                put16(0);
                repeat (n_pre_names) begin
                    k = $urandom_range(4);
                    put8($urandom_range(255, 1));
                    put16(k);
                    put_random(k);
                end
                if (name_size >= 0) begin
                    put8(tse_pkg::NAME_TYPE_HOST);
                    pos_name_size = frame.size();
                    put16(name_size);
                    put_random(name_size);
                end
                patch_len16(pos_list_len);
                patch_len16(pos_sni_len);
            end
            put_other_exts(n_post_ext);
            patch_len16(pos_exts_len);
        end
        patch24(pos_hs_len, frame.size() - pos_hs_len - 3);
        patch_len16(pos_rec_len);
        put_random(tail_len);
    endfunction

    task automatic test_found_name();
        build_hello(32, 4, 1, 1, 1, 1, 0, 5, 0, 0);
        send_frame();
        build_hello(0, 0, 0, 0, 1, 1, 0, 0, 1, 0);
        send_frame();
        build_hello(0, 2, 1, 2, 1, 1, 2, 1, 1, 6);
        send_frame();
    endtask

    task automatic test_rejected_headers();
        frame.delete();
        put8(8'h17); put16(16'h0301); put8(8'h00);
        send_frame();
        build_hello(0, 2, 1, 0, 1, 1, 0, 3, 0, 0);
        frame[tse_pkg::HS_OFF_TYPE] = 8'h02;
        send_frame();
        frame.delete();
        put8(tse_pkg::REC_TYPE_HANDSHAKE); put16(16'h0301);
        put16(tse_pkg::MAX_PACKET_BYTES - 4); put_random(3);
        send_frame();
        frame.delete();
        put8(tse_pkg::REC_TYPE_HANDSHAKE); put16(16'h0301); put16(16'hFFFF);
        send_frame();
        frame.delete();
        put8(tse_pkg::REC_TYPE_HANDSHAKE); put16(16'h0301);
        put16(tse_pkg::MAX_PACKET_BYTES - 5);
        put8(tse_pkg::HS_TYPE_CLIENT_HELLO); put8(0);
        put16(tse_pkg::MAX_PACKET_BYTES - 9); put_random(4);
        send_frame();
        send_byte(tse_pkg::REC_TYPE_HANDSHAKE, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_missing_name();
        build_hello(0, 2, 1, 0, 0, 0, 0, 0, 0, 0);
        send_frame();
        build_hello(0, 2, 1, 0, 1, 0, 0, 0, 0, 0);
        send_frame();
        build_hello(1, 2, 1, 2, 1, 0, 0, 0, 1, 0);
        send_frame();
        build_hello(0, 2, 1, 0, 1, 1, 2, -1, 1, 0);
        send_frame();
    endtask

    task automatic test_bad_lengths();
        build_hello(0, 2, 1, 1, 1, 1, 0, 4, 0, 0);
        bump16(pos_exts_len, 1);
        send_frame();
        build_hello(0, 2, 1, 0, 1, 1, 0, 4, 0, 0);
        bump16(pos_name_size, 1);
        send_frame();
        build_hello(0, 2, 1, 0, 1, 1, 0, 4, 0, 0);
        bump16(pos_sni_len, 2);
        send_frame();
        build_hello(0, 2, 1, 0, 1, 1, 0, 4, 0, 0);
        patch24(pos_hs_len, 10);
        send_frame();
        build_hello(0, 2, 1, 0, 1, 1, 0, 8, 0, 0);
        truncate_frame(frame.size() - 3);
        send_frame();
        build_hello(0, 2, 1, 0, 1, 1, 0, 8, 0, 0);
        truncate_frame(20);
        send_frame();
    endtask

    task automatic test_receiver_hold_off();
        hold_off_left = 300;
        send_gaps     = 1'b0;
        build_hello(0, 2, 1, 0, 1, 1, 0, 200, 0, 0);
        send_frame();
        send_gaps = 1'b1;
    endtask

    task automatic test_long_packet();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        build_hello(0, 2, 1, 0, 1, 1, 0, 3, 0, 100);
        send_frame();
        build_hello(0, 2, 1, 0, 1, 1, 0, 3, 0, 0);
        send_frame();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    task automatic test_random_packets();
        int start;
        int k;
        int cand[6];
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            send_gaps   = $urandom_range(4) != 0;
            recv_stalls = $urandom_range(4) != 0;
            build_hello(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(32),
                        ($urandom_range(9) == 0) ? $urandom_range(300) : 2 * $urandom_range(20),
                        $urandom_range(3), $urandom_range(3),
                        $urandom_range(19) != 0, $urandom_range(6) != 0,
                        ($urandom_range(4) == 0) ? $urandom_range(2, 1) : 0,
                        ($urandom_range(7) == 0) ? 0 : $urandom_range(40, 1),
                        $urandom_range(2),
                        ($urandom_range(4) == 0) ? $urandom_range(10, 1) : 0);
            if ($urandom_range(99) < 30) begin
                case ($urandom_range(5))
                    0: begin
                        cand = '{pos_rec_len, pos_hs_len + 1, pos_exts_len, pos_sni_len,
                                 pos_list_len, pos_name_size};
                        do k = $urandom_range(5); while (cand[k] < 0);
                        bump16(cand[k], $urandom_range(1) ? $urandom_range(4, 1)
                                                          : -int'($urandom_range(4, 1)));
                    end
                    1: truncate_frame($urandom_range(frame.size(), 1));
                    2: frame[0] = $urandom_range(255);
                    3: frame[tse_pkg::HS_OFF_TYPE] = $urandom_range(255);
                    4: begin
                        frame.delete();
                        put_random($urandom_range(40, 1));
                        if ($urandom_range(1)) frame[0] = tse_pkg::REC_TYPE_HANDSHAKE;
                    end
                    default: frame[$urandom_range(frame.size() - 1)] = $urandom_range(255);
                endcase
            end
            send_frame();
        end
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    initial begin
        sni_restart();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_found_name();
        test_rejected_headers();
        test_missing_name();
        test_bad_lengths();
        test_receiver_hold_off();
        test_long_packet();
        test_random_packets();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tse_pkg.sv
rtl/core/tse_parser.sv
rtl/core/tls_sni_extractor.sv
bench/tls_sni_extractor_test.sv
